/* hw/rtl/obp_pkg.sv */
// Shared types, constants and helper functions for the obstacle box outline block.
// Used by every module under hw/rtl but obp_ram; has no dependencies of its own.
`default_nettype none

package obp_pkg;

  // Default heading resolution in bits
  localparam int ANGLE_BITS_DEF = 16;

  // pi/2 in Q30, the step of the sine table argument
  localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

  // Number of Taylor correction terms after x
  localparam logic [2:0] TAYLOR_LAST = 3'd7;

  // Sine magnitude width (Q0.15, 0..32767)
  localparam int SINE_W = 15;

  // Speed threshold after reset: 0.2 m/s in 1/256 m/s
  localparam logic [15:0] SPEED_THR_RESET = 16'd51;

  // Last outline point of an obstacle
  localparam logic [2:0] POINT_LAST = 3'd7;

  // Sine table generator sequence
  typedef enum logic [3:0] {
    GEN_X,
    GEN_SQ,
    GEN_X2,
    GEN_MUL,
    GEN_RECIP,
    GEN_CORR,
    GEN_ACC,
    GEN_WRITE,
    GEN_DONE
  } obp_gen_state_t;

  // Sign of one offset component
  typedef enum logic [1:0] {
    OFF_NEG,
    OFF_ZERO,
    OFF_POS
  } obp_off_t;

  // One obstacle as it arrives
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [15:0]        heading_code;
    logic [15:0]        half_length;
    logic [15:0]        half_width;
    logic [15:0]        speed;
  } obp_item_t;

  // One obstacle after the rotation products
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] a_cos;
    logic signed [31:0] a_sin;
    logic signed [31:0] b_cos;
    logic signed [31:0] b_sin;
    logic               dynamic;
  } obp_prod_t;

  // Taylor divisor (2i)(2i+1) for term i
  function automatic logic [7:0] taylor_div(logic [2:0] i);
    case (i)
      3'd1:    return 8'd6;
      3'd2:    return 8'd20;
      3'd3:    return 8'd42;
      3'd4:    return 8'd72;
      3'd5:    return 8'd110;
      3'd6:    return 8'd156;
      3'd7:    return 8'd210;
      default: return 8'd6;
    endcase
  endfunction

  // floor(2^32 / divisor) for term i
  function automatic logic [29:0] taylor_recip(logic [2:0] i);
    case (i)
      3'd1:    return 30'd715827882;
      3'd2:    return 30'd214748364;
      3'd3:    return 30'd102261126;
      3'd4:    return 30'd59652323;
      3'd5:    return 30'd39045157;
      3'd6:    return 30'd27531841;
      3'd7:    return 30'd20452225;
      default: return 30'd715827882;
    endcase
  endfunction

  // Half-length sign per outline point
  function automatic obp_off_t off_a(logic [2:0] k);
    case (k)
      3'd0, 3'd1, 3'd2: return OFF_NEG;
      3'd4, 3'd5, 3'd6: return OFF_POS;
      default:          return OFF_ZERO;
    endcase
  endfunction

  // Half-width sign per outline point
  function automatic obp_off_t off_b(logic [2:0] k);
    case (k)
      3'd0, 3'd6, 3'd7: return OFF_NEG;
      3'd2, 3'd3, 3'd4: return OFF_POS;
      default:          return OFF_ZERO;
    endcase
  endfunction

  // Apply an offset sign to a product, one bit of headroom
  function automatic logic signed [32:0] off_apply(obp_off_t sel, logic signed [31:0] v);
    logic signed [32:0] ext;
    ext = {v[31], v};
    case (sel)
      OFF_NEG:  return -ext;
      OFF_POS:  return ext;
      default:  return 33'sd0;
    endcase
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/obp_ram.sv */
// Generic simple RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module obp_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 16385
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/obp_sine_gen.sv */
// Quarter-wave sine table generator: Q30 Taylor series per entry, written to the RAM.
// Depends on obp_pkg.
`default_nettype none

module obp_sine_gen #(
  parameter int ANGLE_BITS = obp_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  output logic                                   we,
  output logic [ANGLE_BITS-2:0]                  waddr,
  output logic [obp_pkg::SINE_W-1:0]             wdata,
  output logic                                   done
);

  localparam int QW    = ANGLE_BITS - 2;
  localparam int AW    = ANGLE_BITS - 1;
  localparam int ACC_W = 29 + ANGLE_BITS;
  localparam logic [AW-1:0] QUARTER = {1'b1, {QW{1'b0}}};

  obp_pkg::obp_gen_state_t state, state_next;

  logic [AW-1:0]        k;       // table entry
  logic [ACC_W-1:0]     acc;     // pi/2 * k in Q30, before the shift
  logic [30:0]          x;
  logic [31:0]          x2;
  logic [31:0]          term;
  logic [31:0]          numer;
  logic signed [33:0]   sum;
  logic [63:0]          prod;
  logic [2:0]           i;

  logic [31:0]          q0;
  logic [39:0]          qd;
  logic [39:0]          rem;
  logic [7:0]           dv;
  logic [31:0]          q;
  logic signed [33:0]   sum_pos;
  logic [33:0]          rnd;

  // quotient correction after the reciprocal multiply
  always_comb begin
    dv  = obp_pkg::taylor_div(i);
    q0  = prod[63:32];
    qd  = {8'b0, q0} * {32'b0, dv};
    rem = {8'b0, numer} - qd;
    q   = (rem >= {32'b0, dv}) ? q0 + 32'd1 : q0;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      obp_pkg::GEN_X:     state_next = obp_pkg::GEN_SQ;
      obp_pkg::GEN_SQ:    state_next = obp_pkg::GEN_X2;
      obp_pkg::GEN_X2:    state_next = obp_pkg::GEN_MUL;
      obp_pkg::GEN_MUL:   state_next = obp_pkg::GEN_RECIP;
      obp_pkg::GEN_RECIP: state_next = obp_pkg::GEN_CORR;
      obp_pkg::GEN_CORR:  state_next = obp_pkg::GEN_ACC;
      obp_pkg::GEN_ACC: begin
        state_next = (i == obp_pkg::TAYLOR_LAST) ? obp_pkg::GEN_WRITE : obp_pkg::GEN_MUL;
      end
      obp_pkg::GEN_WRITE: begin
        state_next = (k == QUARTER) ? obp_pkg::GEN_DONE : obp_pkg::GEN_X;
      end
      obp_pkg::GEN_DONE:  state_next = obp_pkg::GEN_DONE;
      default:            state_next = obp_pkg::GEN_X;
    endcase
  end

  // outputs: rounded Q15 entry, clamped to 0..32767
  always_comb begin
    sum_pos = sum[33] ? 34'sd0 : sum;
    rnd     = (34'(sum_pos) + 34'd16384) >> 15;
    we      = (state == obp_pkg::GEN_WRITE);
    done    = (state == obp_pkg::GEN_DONE);
    waddr   = k;
    wdata   = (rnd > 34'd32767) ? {obp_pkg::SINE_W{1'b1}} : rnd[obp_pkg::SINE_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= obp_pkg::GEN_X;
      k     <= '0;
      acc   <= '0;
      i     <= 3'd1;
    end else begin
      state <= state_next;
      if (state == obp_pkg::GEN_X2) begin
        i <= 3'd1;
      end else if (state == obp_pkg::GEN_ACC && i != obp_pkg::TAYLOR_LAST) begin
        i <= i + 3'd1;
      end
      if (state == obp_pkg::GEN_WRITE && k != QUARTER) begin
        k   <= k + AW'(1);
        acc <= acc + ACC_W'(obp_pkg::PI_HALF_Q30);
      end
    end
  end

  // series datapath
  always_ff @(posedge clk) begin
    case (state)
      obp_pkg::GEN_X:  x <= acc[QW +: 31];
      obp_pkg::GEN_SQ: prod <= {2'b0, ({31'b0, x} * {31'b0, x})};
      obp_pkg::GEN_X2: begin
        x2   <= prod[61:30];
        term <= {1'b0, x};
        sum  <= 34'(signed'({3'b0, x}));
      end
      obp_pkg::GEN_MUL: prod <= {32'b0, term} * {32'b0, x2};
      obp_pkg::GEN_RECIP: begin
        numer <= prod[61:30];
        prod  <= {32'b0, prod[61:30]} * {34'b0, obp_pkg::taylor_recip(i)};
      end
      obp_pkg::GEN_CORR: term <= q;
      obp_pkg::GEN_ACC: begin
        if (i[0]) begin
          sum <= sum - signed'({2'b0, term});
        end else begin
          sum <= sum + signed'({2'b0, term});
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/obp_rotate.sv */
// Front pipeline: angle decode, sine table reads and the four rotation products.
// Depends on obp_pkg; reads the table RAM instanced in the top level.
`default_nettype none

module obp_rotate #(
  parameter int ANGLE_BITS = obp_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire obp_pkg::obp_item_t            in_item,
  output logic                               in_ready,
  input  wire logic [15:0]                   threshold,
  input  wire logic                          table_done,
  output logic                               rd_en,
  output logic [ANGLE_BITS-2:0]              rd_addr_sin,
  output logic [ANGLE_BITS-2:0]              rd_addr_cos,
  input  wire logic [obp_pkg::SINE_W-1:0]    rd_data_sin,
  input  wire logic [obp_pkg::SINE_W-1:0]    rd_data_cos,
  output logic                               out_valid,
  output obp_pkg::obp_prod_t                 out_prod,
  input  wire logic                          out_ready
);

  localparam int QW = ANGLE_BITS - 2;
  localparam int AW = ANGLE_BITS - 1;
  localparam logic [AW-1:0]         QUARTER   = {1'b1, {QW{1'b0}}};
  localparam logic [ANGLE_BITS-1:0] QUARTER_A = {2'b01, {QW{1'b0}}};

  // table address for an angle, folding odd quadrants
  function automatic logic [AW-1:0] table_addr(logic [ANGLE_BITS-1:0] ang);
    logic [AW-1:0] idx;
    idx = {1'b0, ang[QW-1:0]};
    return ang[QW] ? QUARTER - idx : idx;
  endfunction

  logic                  front_en;
  logic                  accept;
  logic [ANGLE_BITS-1:0] angle;
  logic [ANGLE_BITS-1:0] cos_angle;

  // stage 1
  logic                  v1;
  logic signed [31:0]    cx1, cy1;
  logic [15:0]           a1, b1;
  logic                  dyn1, sin_neg1, cos_neg1;

  // stage 2
  logic                  v2;
  logic signed [31:0]    cx2, cy2;
  logic [15:0]           a2, b2;
  logic                  dyn2, sin_neg2, cos_neg2;
  logic signed [16:0]    sin_s, cos_s, a_s, b_s;
  logic signed [33:0]    p_ac, p_as, p_bc, p_bs;

  // stage 3
  logic                  v3;

  // pipeline moves when the last stage is empty or handed on
  assign front_en = !v3 || out_ready;
  assign in_ready = front_en && table_done;
  assign accept   = in_valid && in_ready;
  assign rd_en    = front_en;

  assign angle     = in_item.heading_code[15 -: ANGLE_BITS];
  assign cos_angle = angle + QUARTER_A;

  // stage 1: decode and table addresses
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (front_en) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      cx1         <= in_item.center_x;
      cy1         <= in_item.center_y;
      a1          <= in_item.half_length;
      b1          <= in_item.half_width;
      dyn1        <= (in_item.speed > threshold);
      sin_neg1    <= angle[ANGLE_BITS-1];
      cos_neg1    <= cos_angle[ANGLE_BITS-1];
      rd_addr_sin <= table_addr(angle);
      rd_addr_cos <= table_addr(cos_angle);
    end
  end

  // stage 2: table words arrive
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (front_en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      cx2      <= cx1;
      cy2      <= cy1;
      a2       <= a1;
      b2       <= b1;
      dyn2     <= dyn1;
      sin_neg2 <= sin_neg1;
      cos_neg2 <= cos_neg1;
    end
  end

  // signed trig values and products
  always_comb begin
    sin_s = sin_neg2 ? -signed'({2'b0, rd_data_sin}) : signed'({2'b0, rd_data_sin});
    cos_s = cos_neg2 ? -signed'({2'b0, rd_data_cos}) : signed'({2'b0, rd_data_cos});
    a_s   = signed'({1'b0, a2});
    b_s   = signed'({1'b0, b2});
    p_ac  = a_s * cos_s;
    p_as  = a_s * sin_s;
    p_bc  = b_s * cos_s;
    p_bs  = b_s * sin_s;
  end

  // stage 3: products registered
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (front_en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      out_prod.center_x <= cx2;
      out_prod.center_y <= cy2;
      out_prod.a_cos    <= p_ac[31:0];
      out_prod.a_sin    <= p_as[31:0];
      out_prod.b_cos    <= p_bc[31:0];
      out_prod.b_sin    <= p_bs[31:0];
      out_prod.dynamic  <= dyn2;
    end
  end

  assign out_valid = v3;

endmodule

`default_nettype wire

/* hw/rtl/obp_points.sv */
// Point serialiser and back pipeline: offset sum, rounding, centre add, saturation.
// Depends on obp_pkg.
`default_nettype none

module obp_points (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire obp_pkg::obp_prod_t in_prod,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_index,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic                    out_dynamic,
  output logic                    out_last
);

  logic                 en;
  logic                 hv;
  logic [2:0]           k;
  obp_pkg::obp_prod_t   hold;
  obp_pkg::obp_off_t    sa, sb;

  logic                 b1v;
  logic signed [32:0]   px, py;
  logic signed [31:0]   cx1, cy1;
  logic [2:0]           k1;
  logic                 dyn1;

  logic signed [32:0]   sum_x, sum_y;

  assign en       = !out_valid || out_ready;
  assign in_ready = en && (!hv || k == obp_pkg::POINT_LAST);

  // hold stage: one obstacle, stepped through its eight points
  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
      k  <= '0;
    end else if (en) begin
      if (!hv || k == obp_pkg::POINT_LAST) begin
        hv <= in_valid;
        k  <= '0;
      end else begin
        k <= k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      hold <= in_prod;
    end
  end

  assign sa = obp_pkg::off_a(k);
  assign sb = obp_pkg::off_b(k);

  // stage B1: rotated offset plus half an LSB of Q15
  always_ff @(posedge clk) begin
    if (rst) begin
      b1v <= 1'b0;
    end else if (en) begin
      b1v <= hv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px   <= obp_pkg::off_apply(sa, hold.a_cos) - obp_pkg::off_apply(sb, hold.b_sin)
              + 33'sd16384;
      py   <= obp_pkg::off_apply(sa, hold.a_sin) + obp_pkg::off_apply(sb, hold.b_cos)
              + 33'sd16384;
      cx1  <= hold.center_x;
      cy1  <= hold.center_y;
      k1   <= k;
      dyn1 <= hold.dynamic;
    end
  end

  // floor shift and centre add, exact in 33 bits
  always_comb begin
    sum_x = {cx1[31], cx1} + {{15{px[32]}}, px[32:15]};
    sum_y = {cy1[31], cy1} + {{15{py[32]}}, py[32:15]};
  end

  // stage B2: saturate into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b1v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sum_x[32] != sum_x[31]) begin
        out_x <= sum_x[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end else begin
        out_x <= sum_x[31:0];
      end
      if (sum_y[32] != sum_y[31]) begin
        out_y <= sum_y[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end else begin
        out_y <= sum_y[31:0];
      end
      out_index   <= k1;
      out_dynamic <= dyn1;
      out_last    <= (k1 == obp_pkg::POINT_LAST);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/obstacle_box_points_top.sv */
// Top level of the obstacle box outline block: ports, threshold register, table RAM.
// Depends on obp_pkg, obp_ram, obp_sine_gen, obp_rotate and obp_points.
//
// Usage:
//  - s_* channel takes one obstacle per word; m_* gives its eight outline points,
//    point 0 to 7, with m_tlast on point 7. A word moves when tvalid and tready
//    are both high at a rising clock edge.
//  - cfg_* writes the speed threshold (1/256 m/s); cfg_ready is always high.
//    Write it only while no obstacle is in flight.
//  - After reset the sine table is built in the RAM, 2^(ANGLE_BITS-2) + 1 entries
//    one after another. s_tready is low until it is done; the threshold resets to
//    51.
//  - A point passes the front stages, the hold stage and stages B1 and B2.
//  - Throughput: one point per cycle while m_tready is high, one obstacle per eight
//    points, set by the single result channel. A new obstacle is taken while the
//    previous one is still being serialised.
//  - When m_tready is low the stages fill and hold; nothing is lost or repeated, and
//    s_tready drops once the front stages are full.
`default_nettype none

module obstacle_box_points_top #(
  parameter int ANGLE_BITS = obp_pkg::ANGLE_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // center_x[31:0], center_y[63:32], heading_code[79:64], half_length[95:80],
  // half_width[111:96], speed[127:112]
  input  wire logic [127:0] s_tdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // point_x[31:0], point_y[63:32]
  output logic [63:0]       m_tdata,
  // point_index[2:0], is_dynamic[3]
  output logic [3:0]        m_tuser,
  output logic              m_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         cfg_valid,
  output logic              cfg_ready
);

  localparam int AW    = ANGLE_BITS - 1;
  localparam int DEPTH = (1 << (ANGLE_BITS - 2)) + 1;

  logic [15:0]                      speed_threshold;
  obp_pkg::obp_item_t               item;
  obp_pkg::obp_prod_t               prod;
  logic                             prod_valid, prod_ready;

  logic                             gen_we, gen_done;
  logic [AW-1:0]                    gen_addr;
  logic [obp_pkg::SINE_W-1:0]       gen_data;
  logic                             rd_en;
  logic [AW-1:0]                    rd_addr_sin, rd_addr_cos;
  logic [obp_pkg::SINE_W-1:0]       rd_data_sin, rd_data_cos;

  logic [2:0]                       pt_index;
  logic signed [31:0]               pt_x, pt_y;
  logic                             pt_dynamic;

  // threshold register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_threshold <= obp_pkg::SPEED_THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      speed_threshold <= cfg_data;
    end
  end

  // unpack the input word
  always_comb begin
    item.center_x     = s_tdata[31:0];
    item.center_y     = s_tdata[63:32];
    item.heading_code = s_tdata[79:64];
    item.half_length  = s_tdata[95:80];
    item.half_width   = s_tdata[111:96];
    item.speed        = s_tdata[127:112];
  end

  obp_sine_gen #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_gen (
    .clk   (clk),
    .rst   (rst),
    .we    (gen_we),
    .waddr (gen_addr),
    .wdata (gen_data),
    .done  (gen_done)
  );

  obp_ram #(
    .WIDTH (obp_pkg::SINE_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (gen_we),
    .waddr   (gen_addr),
    .wdata   (gen_data),
    .re      (rd_en),
    .raddr_a (rd_addr_sin),
    .raddr_b (rd_addr_cos),
    .rdata_a (rd_data_sin),
    .rdata_b (rd_data_cos)
  );

  obp_rotate #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_rotate (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_item     (item),
    .in_ready    (s_tready),
    .threshold   (speed_threshold),
    .table_done  (gen_done),
    .rd_en       (rd_en),
    .rd_addr_sin (rd_addr_sin),
    .rd_addr_cos (rd_addr_cos),
    .rd_data_sin (rd_data_sin),
    .rd_data_cos (rd_data_cos),
    .out_valid   (prod_valid),
    .out_prod    (prod),
    .out_ready   (prod_ready)
  );

  obp_points u_points (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (prod_valid),
    .in_prod     (prod),
    .in_ready    (prod_ready),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_index   (pt_index),
    .out_x       (pt_x),
    .out_y       (pt_y),
    .out_dynamic (pt_dynamic),
    .out_last    (m_tlast)
  );

  assign m_tdata = {pt_y, pt_x};
  assign m_tuser = {pt_dynamic, pt_index};

endmodule

`default_nettype wire

/* dv/obstacle_box_points_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for obstacle_box_points_top: obstacles in, eight outline points out.
// Depends on obp_pkg and the block's RTL; a scoreboard class predicts every point.

module obstacle_box_points_top_tb;

  localparam int ANGLE_BITS    = obp_pkg::ANGLE_BITS_DEF;
  localparam int QUARTER       = 1 << (ANGLE_BITS - 2);
  localparam int ANGLE_MASK    = (1 << ANGLE_BITS) - 1;
  localparam int DRAIN_CYCLES  = 16;
  localparam int STALL_MAX     = 11;
  // idle limit: four times the table build after reset, plus a margin
  localparam int IDLE_LIMIT    = 4 * 32 * (QUARTER + 1) + 20000;
  localparam int PHASE_ITEMS   = 55;
  localparam int PHASE0_RANDOM = 45;

  // outline offset signs, point 0 to 7
  localparam int LEN_SIGN [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};
  localparam int WID_SIGN [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};

  typedef struct {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [15:0]        heading_code;
    logic [15:0]        half_length;
    logic [15:0]        half_width;
    logic [15:0]        speed;
  } obstacle_t;

  typedef struct {
    logic [2:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               is_dynamic;
    logic               last_point;
  } outline_point_t;

  // Predicts the outline of each obstacle and checks the points in order
  class box_outline_scoreboard;
    int unsigned    sine_tab [0:QUARTER];
    logic [15:0]    speed_limit;
    outline_point_t expected_points [$];
    int unsigned    fail_count;

    // quarter-wave sine in Q0.15 from a truncating Q30 Taylor series
    function void init();
      longint unsigned x, x2, term;
      longint          sum, r;
      for (int k = 0; k <= QUARTER; k++) begin
        x    = (64'd1686629713 * longint'(k)) / longint'(QUARTER);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int i = 1; i <= 7; i++) begin
          term = (term * x2) >> 30;
          term = term / longint'((2 * i) * (2 * i + 1));
          if (i % 2 == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        r = (sum + 16384) >>> 15;
        if (r > 32767) r = 32767;
        sine_tab[k] = int'(r);
      end
      speed_limit = obp_pkg::SPEED_THR_RESET;
      fail_count  = 0;
    endfunction

    function longint signed_sine(int unsigned angle);
      int unsigned quad, idx;
      longint      v;
      quad = (angle >> (ANGLE_BITS - 2)) & 3;
      idx  = angle & (QUARTER - 1);
      if (quad[0]) v = longint'(sine_tab[QUARTER - idx]);
      else v = longint'(sine_tab[idx]);
      return quad[1] ? -v : v;
    endfunction

    function logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function void note_obstacle(obstacle_t ob);
      int unsigned    angle;
      longint         s, c, dx, dy, rx, ry;
      outline_point_t p;
      angle = (int'(ob.heading_code) >> (16 - ANGLE_BITS)) & ANGLE_MASK;
      s     = signed_sine(angle);
      c     = signed_sine((angle + QUARTER) & ANGLE_MASK);
      for (int k = 0; k < 8; k++) begin
        dx = longint'(ob.half_length) * LEN_SIGN[k];
        dy = longint'(ob.half_width) * WID_SIGN[k];
        // round half up: floor((p + 2^14) / 2^15)
        rx = (dx * c - dy * s + 16384) >>> 15;
        ry = (dx * s + dy * c + 16384) >>> 15;
        p.point_index = 3'(k);
        p.point_x     = clamp32(longint'(ob.center_x) + rx);
        p.point_y     = clamp32(longint'(ob.center_y) + ry);
        p.is_dynamic  = ob.speed > speed_limit;
        p.last_point  = (3'(k) == obp_pkg::POINT_LAST);
        expected_points = {expected_points, p};
      end
    endfunction

    function void check_point(outline_point_t got);
      outline_point_t want;
      if (expected_points.size() == 0) begin
        $error("unexpected point word: index %0d x %0d y %0d",
               got.point_index, got.point_x, got.point_y);
        fail_count++;
        return;
      end
      want = expected_points.pop_front();
      if (got.point_index !== want.point_index) begin
        $error("point_index: expected %0d, got %0d", want.point_index, got.point_index);
        fail_count++;
      end
      if (got.point_x !== want.point_x) begin
        $error("point_x: expected %0d, got %0d", want.point_x, got.point_x);
        fail_count++;
      end
      if (got.point_y !== want.point_y) begin
        $error("point_y: expected %0d, got %0d", want.point_y, got.point_y);
        fail_count++;
      end
      if (got.is_dynamic !== want.is_dynamic) begin
        $error("is_dynamic: expected %0d, got %0d", want.is_dynamic, got.is_dynamic);
        fail_count++;
      end
      if (got.last_point !== want.last_point) begin
        $error("last_point: expected %0d, got %0d", want.last_point, got.last_point);
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic [127:0] s_tdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  m_tdata;
  logic [3:0]   m_tuser;
  logic         m_tlast;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  cfg_data = '0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;

  box_outline_scoreboard sb;
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  int unsigned points_taken = 0;
  int unsigned idle_cycles = 0;

  obstacle_box_points_top #(.ANGLE_BITS(ANGLE_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_data (cfg_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Accepted words: threshold writes, obstacles and outline points
  always @(posedge clk) begin
    obstacle_t      ob;
    outline_point_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.speed_limit = cfg_data;
      if (s_tvalid && s_tready) begin
        ob.center_x     = s_tdata[31:0];
        ob.center_y     = s_tdata[63:32];
        ob.heading_code = s_tdata[79:64];
        ob.half_length  = s_tdata[95:80];
        ob.half_width   = s_tdata[111:96];
        ob.speed        = s_tdata[127:112];
        sb.note_obstacle(ob);
      end
      if (m_tvalid && m_tready) begin
        got.point_index = m_tuser[2:0];
        got.is_dynamic  = m_tuser[3];
        got.point_x     = m_tdata[31:0];
        got.point_y     = m_tdata[63:32];
        got.last_point  = m_tlast;
        sb.check_point(got);
        points_taken++;
      end
    end
  end

  // Watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver back-pressure: a fresh stall drawn after each point word
  always @(negedge clk) begin
    static int unsigned seen_taken = 0;
    static int unsigned stall_left = 0;
    if (seen_taken != points_taken) begin
      seen_taken = points_taken;
      stall_left = rx_idle ? $urandom_range(0, STALL_MAX) : 0;
    end
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_obstacle(input obstacle_t ob);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, STALL_MAX) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ob.speed, ob.half_width, ob.half_length, ob.heading_code,
                 ob.center_y, ob.center_x};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Sender holds off until every outstanding point has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic obstacle_t make_obstacle(logic [31:0] cx, logic [31:0] cy,
                                              logic [15:0] hd, logic [15:0] a,
                                              logic [15:0] b, logic [15:0] sp);
    obstacle_t ob;
    ob.center_x     = cx;
    ob.center_y     = cy;
    ob.heading_code = hd;
    ob.half_length  = a;
    ob.half_width   = b;
    ob.speed        = sp;
    return ob;
  endfunction

  function automatic logic [31:0] random_center();
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF - $urandom_range(0, 100000);
      1:       return 32'h8000_0000 + $urandom_range(0, 100000);
      2:       return 32'($urandom_range(0, 400000)) - 32'd200000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] random_extent();
    if ($urandom_range(0, 2) == 0) return 16'($urandom_range(0, 300));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] random_speed(logic [15:0] limit);
    int sp;
    if ($urandom_range(0, 2) != 0) return 16'($urandom);
    sp = int'(limit) + $urandom_range(0, 2) - 1;
    if (sp < 0) sp = 0;
    if (sp > 65535) sp = 65535;
    return 16'(sp);
  endfunction

  function automatic obstacle_t random_obstacle(logic [15:0] limit);
    logic [15:0] hd;
    // quadrant edges get extra weight
    if ($urandom_range(0, 4) == 0) hd = 16'($urandom_range(0, 3) * QUARTER)
                                        + 16'($urandom_range(0, 2)) - 16'd1;
    else hd = 16'($urandom);
    return make_obstacle(random_center(), random_center(), hd,
                         random_extent(), random_extent(), random_speed(limit));
  endfunction

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 16 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      send_obstacle(random_obstacle(sb.speed_limit));
    end
  endtask

  initial begin
    obstacle_t   directed [$];
    logic [15:0] limits [4];
    sb = new;
    sb.init();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes, every quadrant edge, saturation and the threshold boundary
    directed = {directed, make_obstacle(0, 0, 0, 0, 0, 0)};
    directed = {directed, make_obstacle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 16'hFFFF, 16'hFFFF,
                                        16'hFFFF)};
    directed = {directed, make_obstacle(32'h8000_0000, 32'h8000_0000, 0, 16'hFFFF, 16'hFFFF,
                                        16'd51)};
    directed = {directed, make_obstacle(32'h7FFF_FFFF, 32'h8000_0000, 16'd16384, 16'hFFFF,
                                        16'hFFFF, 16'd52)};
    directed = {directed, make_obstacle(32'h8000_0000, 32'h7FFF_FFFF, 16'd32768, 16'hFFFF,
                                        16'hFFFF, 16'd50)};
    directed = {directed, make_obstacle(32'h8000_0000, 32'h7FFF_FFFF, 16'd49152, 16'hFFFF,
                                        16'hFFFF, 16'd52)};
    directed = {directed, make_obstacle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd8192, 16'hFFFF,
                                        16'hFFFF, 16'd0)};
    directed = {directed, make_obstacle(32'h8000_0000, 32'h8000_0000, 16'd40960, 16'hFFFF,
                                        16'hFFFF, 16'd51)};
    foreach (limits[i]) limits[i] = 16'd0;
    for (int h = 0; h < 4; h++) begin
      directed = {directed, make_obstacle($urandom, $urandom, 16'(h * QUARTER) - 16'd1,
                                          16'd4000, 16'd1500, 16'd52)};
      directed = {directed, make_obstacle($urandom, $urandom, 16'(h * QUARTER) + 16'd1,
                                          16'd1500, 16'd4000, 16'd51)};
    end
    directed = {directed, make_obstacle(32'd1000, -32'sd1000, 16'hFFFF, 16'd1, 16'd1,
                                        16'hFFFF)};
    directed = {directed, make_obstacle(-32'sd5, 32'd5, 16'hAAAA, 16'h5555, 16'hAAAA,
                                        16'h5555)};
    directed = {directed, make_obstacle(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA,
                                        16'h5555, 16'hAAAA)};
    directed = {directed, make_obstacle(0, 0, 16'd12345, 16'd0, 16'hFFFF, 16'd1)};
    directed = {directed, make_obstacle(0, 0, 16'd54321, 16'hFFFF, 16'd0, 16'd1)};
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    foreach (directed[i]) send_obstacle(directed[i]);

    // first phase runs on the threshold left by reset
    send_random(PHASE0_RANDOM / 2);
    wait_drained();
    send_random(PHASE0_RANDOM - PHASE0_RANDOM / 2);
    wait_drained();

    limits[0] = 16'd0;
    limits[1] = 16'hFFFF;
    limits[2] = 16'($urandom);
    limits[3] = 16'd1000;
    foreach (limits[i]) begin
      write_threshold(limits[i]);
      send_random(PHASE_ITEMS);
      wait_drained();
    end

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/obp_pkg.sv
hw/rtl/obp_ram.sv
hw/rtl/obp_sine_gen.sv
hw/rtl/obp_rotate.sv
hw/rtl/obp_points.sv
hw/rtl/obstacle_box_points_top.sv
dv/obstacle_box_points_top_tb.sv
